// ===== src/uts_pkg.sv =====
// Package with the shared types, constants and lookup functions of the slug encoder.
`default_nettype none
package uts_pkg;

  localparam int LEN_WIDTH   = 8;
  localparam int DEFAULT_LEN = 10;
  localparam int DEF_W       = $clog2(DEFAULT_LEN + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] MASK_E0    = 8'hE0;
  localparam logic [7:0] MASK_F0    = 8'hF0;
  localparam logic [7:0] MASK_F8    = 8'hF8;
  localparam logic [7:0] LEAD_2B    = 8'hC0;
  localparam logic [7:0] LEAD_3B    = 8'hE0;
  localparam logic [7:0] LEAD_4B    = 8'hF0;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] MAX_LEN_RESET = 8'd63;

  typedef struct packed {
    logic             is_term;
    logic             with_us;
    logic [7:0]       ch;
    logic [DEF_W-1:0] def_cnt;
  } cmd_t;

  function automatic logic [7:0] accent_map(input logic [5:0] idx);
    logic [7:0] ch;
    unique case (idx)
      6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05: ch = "A";
      6'h07: ch = "C";
      6'h08, 6'h09, 6'h0A, 6'h0B: ch = "E";
      6'h0C, 6'h0D, 6'h0E, 6'h0F: ch = "I";
      6'h11: ch = "N";
      6'h12, 6'h13, 6'h14, 6'h15, 6'h16, 6'h18: ch = "O";
      6'h19, 6'h1A, 6'h1B, 6'h1C: ch = "U";
      6'h1D: ch = "Y";
      6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25: ch = "a";
      6'h27: ch = "c";
      6'h28, 6'h29, 6'h2A, 6'h2B: ch = "e";
      6'h2C, 6'h2D, 6'h2E, 6'h2F: ch = "i";
      6'h31: ch = "n";
      6'h32, 6'h33, 6'h34, 6'h35, 6'h36, 6'h38: ch = "o";
      6'h39, 6'h3A, 6'h3B, 6'h3C: ch = "u";
      6'h3D, 6'h3F: ch = "y";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] default_word(input logic [DEF_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      DEF_W'(0): ch = "c";
      DEF_W'(1): ch = "o";
      DEF_W'(2): ch = "m";
      DEF_W'(3): ch = "p";
      DEF_W'(4): ch = "e";
      DEF_W'(5): ch = "t";
      DEF_W'(6): ch = "i";
      DEF_W'(7): ch = "c";
      DEF_W'(8): ch = "a";
      DEF_W'(9): ch = "o";
      default:   ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== src/uts_front.sv =====
// Front end: accepts bytes, decodes UTF-8, tracks separators and length, issues commands.
`default_nettype none
module uts_front
  import uts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [7:0]           max_out_len_r;
  logic                 pending_sep_r, pending_sep_nxt;
  logic                 last_was_sep_r, last_was_sep_nxt;
  logic [1:0]           skip_left_r, skip_left_nxt;
  logic                 after_c3_r, after_c3_nxt;
  logic [LEN_WIDTH-1:0] emitted_r, emitted_nxt;
  logic                 full_r, full_nxt;

  logic                 accept;
  logic [LEN_WIDTH-1:0] limit;
  logic [LEN_WIDTH:0]   cnt_plus1, cnt_plus2;
  logic                 is_alnum;
  logic [7:0]           mapped;
  logic                 is_letter, is_sep;
  logic [7:0]           letter_ch;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign limit     = LEN_WIDTH'(max_out_len_r);
  assign cnt_plus1 = {1'b0, emitted_r} + (LEN_WIDTH+1)'(1);
  assign cnt_plus2 = {1'b0, emitted_r} + (LEN_WIDTH+1)'(2);
  assign mapped    = accent_map(in_byte[5:0]);
  assign is_alnum  = (in_byte >= "0" && in_byte <= "9") ||
                     (in_byte >= "A" && in_byte <= "Z") ||
                     (in_byte >= "a" && in_byte <= "z");

  always_comb begin
    pending_sep_nxt  = pending_sep_r;
    last_was_sep_nxt = last_was_sep_r;
    skip_left_nxt    = skip_left_r;
    after_c3_nxt     = after_c3_r;
    emitted_nxt      = emitted_r;
    full_nxt         = full_r;
    q_push           = 1'b0;
    q_cmd            = '0;
    is_letter        = 1'b0;
    is_sep           = 1'b0;
    letter_ch        = in_byte;
    if (accept) begin
      if (in_byte == CH_NUL) begin
        q_push        = 1'b1;
        q_cmd.is_term = 1'b1;
        if (emitted_r == '0) begin
          q_cmd.def_cnt = (limit >= LEN_WIDTH'(DEFAULT_LEN)) ? DEF_W'(DEFAULT_LEN)
                                                             : DEF_W'(limit);
        end
        pending_sep_nxt  = 1'b0;
        last_was_sep_nxt = 1'b1;
        skip_left_nxt    = 2'd0;
        after_c3_nxt     = 1'b0;
        emitted_nxt      = '0;
        full_nxt         = 1'b0;
      end else if (full_r) begin
        full_nxt = 1'b1;
      end else if (skip_left_r != 2'd0) begin
        skip_left_nxt = skip_left_r - 2'd1;
      end else if (after_c3_r) begin
        after_c3_nxt = 1'b0;
        if (in_byte >= CONT_LO && in_byte <= CONT_HI && mapped != CH_NUL) begin
          is_letter = 1'b1;
          letter_ch = mapped;
        end else begin
          is_sep = 1'b1;
        end
      end else if (in_byte < ASCII_TOP) begin
        is_letter = is_alnum;
        is_sep    = !is_alnum;
      end else if (in_byte == LEAD_C3) begin
        after_c3_nxt = 1'b1;
      end else begin
        if ((in_byte & MASK_E0) == LEAD_2B) begin
          skip_left_nxt = 2'd1;
        end else if ((in_byte & MASK_F0) == LEAD_3B) begin
          skip_left_nxt = 2'd2;
        end else if ((in_byte & MASK_F8) == LEAD_4B) begin
          skip_left_nxt = 2'd3;
        end
        is_sep = 1'b1;
      end

      if (is_sep && !last_was_sep_r) begin
        pending_sep_nxt  = 1'b1;
        last_was_sep_nxt = 1'b1;
      end

      if (is_letter) begin
        q_cmd.ch = letter_ch;
        if (pending_sep_r) begin
          if (cnt_plus2 <= {1'b0, limit}) begin
            q_push          = 1'b1;
            q_cmd.with_us   = 1'b1;
            emitted_nxt     = cnt_plus2[LEN_WIDTH-1:0];
            pending_sep_nxt = 1'b0;
          end else begin
            full_nxt = 1'b1;
          end
        end else if (cnt_plus1 <= {1'b0, limit}) begin
          q_push      = 1'b1;
          emitted_nxt = cnt_plus1[LEN_WIDTH-1:0];
        end else begin
          full_nxt = 1'b1;
        end
        last_was_sep_nxt = 1'b0;
        if (emitted_nxt >= limit) begin
          full_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_len_r  <= MAX_LEN_RESET;
      pending_sep_r  <= 1'b0;
      last_was_sep_r <= 1'b1;
      skip_left_r    <= 2'd0;
      after_c3_r     <= 1'b0;
      emitted_r      <= '0;
      full_r         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_out_len_r <= cfg_data;
      end
      pending_sep_r  <= pending_sep_nxt;
      last_was_sep_r <= last_was_sep_nxt;
      skip_left_r    <= skip_left_nxt;
      after_c3_r     <= after_c3_nxt;
      emitted_r      <= emitted_nxt;
      full_r         <= full_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/uts_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module uts_cmd_fifo
  import uts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/uts_back.sv =====
// Back end: expands commands into slug characters and drives the output register.
`default_nettype none
module uts_back
  import uts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_char,
  output logic       out_end_of_slug
);

  cmd_t             cur_r;
  logic             cur_valid_r;
  logic [DEF_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_end_r;

  logic             adv, last;
  logic [7:0]       res_char;
  logic             res_end;

  assign adv = cur_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    res_char = cur_r.ch;
    res_end  = 1'b0;
    last     = 1'b1;
    if (cur_r.is_term) begin
      if (idx_r < cur_r.def_cnt) begin
        res_char = default_word(idx_r);
        last     = 1'b0;
      end else begin
        res_char = CH_NUL;
        res_end  = 1'b1;
      end
    end else if (cur_r.with_us && idx_r == '0) begin
      res_char = CH_UNDER;
      last     = 1'b0;
    end
  end

  assign q_pop = !q_empty && (!cur_valid_r || (adv && last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (adv) begin
      out_char_r <= res_char;
      out_end_r  <= res_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (adv && last) begin
        cur_valid_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + DEF_W'(1);
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_end_of_slug = out_end_r;

endmodule
`default_nettype wire

// ===== src/utf8_text_slug_encoder_top.sv =====
// Top level of the UTF-8 text slug encoder.
// The input channel takes one UTF-8 byte per request; a zero byte ends the string.
// The output channel delivers one slug character per request; the request with
// out_end_of_slug high carries a zero character and closes the slug.
// The configuration channel writes max_out_len, the most slug characters per string;
// the user must write it only with no string in flight; the block does not enforce it.
// An input byte is taken every cycle while the command queue has room. Each byte
// leaves one command at most, and the back end turns a command into one to eleven
// output requests, one per cycle while the receiver is ready: a letter gives one, a
// letter after a held-back separator gives two, and the zero byte gives the default
// word, when the string has emitted nothing, and then the terminator.
// Sustained rate is one byte per cycle, bounded by the back end's one output per cycle
// while the receiver is ready. When it stalls, the output register holds its request,
// the back end waits, the four-entry queue fills, and then in_ready drops.
// Synchronous reset sets max_out_len to 63, clears the queue and the output valid
// flag, and returns the string state to the start of a string.
`default_nettype none
module utf8_text_slug_encoder_top
  import uts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_end_of_slug,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  uts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  uts_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  uts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_end_of_slug (out_end_of_slug)
  );

endmodule
`default_nettype wire
